FILE: rtl/rfv_pkg.sv
`timescale 1ns / 1ps
package rfv_pkg;
    // number format of all components
    localparam int FRAC      = 16;
    localparam int FIELD_W   = 18;
    localparam int THR_W     = 17;

    // internal widths
    localparam int WD_W      = 20;   // (w*d) >> FRAC
    localparam int WC_W      = 23;   // (w*c) >> FRAC
    localparam int RAD_A_W   = 44;   // det << FRAC
    localparam int RAD_B_W   = 62;   // |v|^2 after normalize
    localparam int V_W       = 31;   // normalized component, signed
    localparam int MAG_W     = 30;   // normalized magnitude
    localparam int Q_W       = 17;   // quotient bits
    localparam int NORM_STEPS = 5;   // shifts of 16, 8, 4, 2, 1

    // register map, decoded on paddr[2]
    localparam logic REG_TIR_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] TIR_THRESHOLD_RST = 17'd1;

    typedef logic [2:0][V_W-1:0]     t_vec3;
    typedef logic [2:0][MAG_W-1:0]   t_mag3;

    typedef struct packed {
        logic                          tir;
        logic signed [WC_W-1:0]        wc;
        logic [2:0][FIELD_W-1:0]       n;
        logic [2:0][WD_W-1:0]          wd;
    } t_side_a;

    typedef struct packed {
        logic tir;
        logic zero;
    } t_flags;

    typedef struct packed {
        t_flags      flags;
        logic [2:0]  neg;
        t_mag3       mag;
    } t_side_b;

    typedef struct packed {
        t_flags      flags;
        logic [2:0]  neg;
    } t_side_d;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic                      tir;
    } t_result;
endpackage

FILE: rtl/rfv_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module rfv_sqrt #(
    parameter int RAD_W  = 44,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int ROOT_W = RAD_W / 2;

    logic              r_vld  [ROOT_W];
    logic [RAD_W-1:0]  r_x    [ROOT_W];
    logic [RAD_W-1:0]  r_res  [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (RAD_W - 2 - 2*g);
        logic              cur_vld;
        logic [RAD_W-1:0]  cur_x;
        logic [RAD_W-1:0]  cur_res;
        logic [SIDE_W-1:0] cur_side;
        logic [RAD_W:0]    trial;
        logic              take;

        if (g == 0) begin : g_first
            assign cur_vld  = i_valid;
            assign cur_x    = i_rad;
            assign cur_res  = '0;
            assign cur_side = i_side;
        end else begin : g_next
            assign cur_vld  = r_vld[g-1];
            assign cur_x    = r_x[g-1];
            assign cur_res  = r_res[g-1];
            assign cur_side = r_side[g-1];
        end

        assign trial = {1'b0, cur_res} + BIT;
        assign take  = {1'b0, cur_x} >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= take ? cur_x - trial[RAD_W-1:0] : cur_x;
                r_res[g]  <= take ? (cur_res >> 1) + BIT[RAD_W-1:0] : cur_res >> 1;
                r_side[g] <= cur_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1][ROOT_W-1:0];
    assign o_side  = r_side[ROOT_W-1];
endmodule

FILE: rtl/rfv_norm.sv
`timescale 1ns / 1ps
// Leading-zero normalize: shift by 16, 8, 4, 2, 1 until the max magnitude
// has its top bit set.
module rfv_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rfv_pkg::t_vec3  i_v,
    input  logic [rfv_pkg::MAG_W-1:0] i_m,
    input  rfv_pkg::t_flags i_flags,
    output logic            o_valid,
    output rfv_pkg::t_vec3  o_v,
    output rfv_pkg::t_flags o_flags
);
    import rfv_pkg::*;

    logic             r_vld   [NORM_STEPS];
    t_vec3            r_v     [NORM_STEPS];
    logic [MAG_W-1:0] r_m     [NORM_STEPS];
    t_flags           r_flags [NORM_STEPS];

    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_stage
        localparam int SH = 1 << (NORM_STEPS - 1 - g);
        logic             cur_vld;
        t_vec3            cur_v;
        logic [MAG_W-1:0] cur_m;
        t_flags           cur_flags;
        logic             shift;

        if (g == 0) begin : g_first
            assign cur_vld   = i_valid;
            assign cur_v     = i_v;
            assign cur_m     = i_m;
            assign cur_flags = i_flags;
        end else begin : g_next
            assign cur_vld   = r_vld[g-1];
            assign cur_v     = r_v[g-1];
            assign cur_m     = r_m[g-1];
            assign cur_flags = r_flags[g-1];
        end

        assign shift = (cur_m[MAG_W-1 -: SH] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    r_v[g][l] <= shift ? cur_v[l] << SH : cur_v[l];
                end
                r_m[g]     <= shift ? cur_m << SH : cur_m;
                r_flags[g] <= cur_flags;
            end
        end
    end

    assign o_valid = r_vld[NORM_STEPS-1];
    assign o_v     = r_v[NORM_STEPS-1];
    assign o_flags = r_flags[NORM_STEPS-1];
endmodule

FILE: rtl/rfv_div.sv
`timescale 1ns / 1ps
// Three-lane restoring divider, (mag << FRAC) / len, one quotient bit per stage.
module rfv_div #(
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rfv_pkg::t_mag3        i_mag,
    input  logic [rfv_pkg::V_W-1:0] i_len,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [2:0][rfv_pkg::Q_W-1:0] o_q,
    output logic [SIDE_W-1:0]     o_side
);
    import rfv_pkg::*;

    localparam int N_W = 1 + MAG_W + FRAC;

    logic                    r_vld  [Q_W];
    logic [2:0][N_W-1:0]     r_rem  [Q_W];
    logic [2:0][Q_W-1:0]     r_q    [Q_W];
    logic [V_W-1:0]          r_len  [Q_W];
    logic [SIDE_W-1:0]       r_side [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic                cur_vld;
        logic [2:0][N_W-1:0] cur_rem;
        logic [2:0][Q_W-1:0] cur_q;
        logic [V_W-1:0]      cur_len;
        logic [SIDE_W-1:0]   cur_side;
        logic [N_W-1:0]      dsh;

        if (g == 0) begin : g_first
            assign cur_vld  = i_valid;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign cur_rem[l] = {1'b0, i_mag[l], FRAC'(0)};
            end
            assign cur_q    = '0;
            assign cur_len  = i_len;
            assign cur_side = i_side;
        end else begin : g_next
            assign cur_vld  = r_vld[g-1];
            assign cur_rem  = r_rem[g-1];
            assign cur_q    = r_q[g-1];
            assign cur_len  = r_len[g-1];
            assign cur_side = r_side[g-1];
        end

        assign dsh = {(N_W-V_W)'(0), cur_len} << (Q_W - 1 - g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= cur_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    if (cur_rem[l] >= dsh) begin
                        r_rem[g][l] <= cur_rem[l] - dsh;
                        r_q[g][l]   <= {cur_q[l][Q_W-2:0], 1'b1};
                    end else begin
                        r_rem[g][l] <= cur_rem[l];
                        r_q[g][l]   <= {cur_q[l][Q_W-2:0], 1'b0};
                    end
                end
                r_len[g]  <= cur_len;
                r_side[g] <= cur_side;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_q     = r_q[Q_W-1];
    assign o_side  = r_side[Q_W-1];
endmodule

FILE: rtl/rfv_skid.sv
`timescale 1ns / 1ps
// Output register plus one skid entry; o_ready is registered.
module rfv_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rfv_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output rfv_pkg::t_result o_data,
    input  logic             i_ready
);
    logic             r_o_valid;
    logic             r_s_valid;
    rfv_pkg::t_result r_o;
    rfv_pkg::t_result r_s;
    logic             push;
    logic             take;

    assign push = i_valid && !r_s_valid;
    assign take = r_o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (r_s_valid) begin
            if (take) begin
                r_s_valid <= 1'b0;
            end
        end else if (!r_o_valid || take) begin
            r_o_valid <= push;
        end else if (push) begin
            r_s_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            if (take) begin
                r_o <= r_s;
            end
        end else if (!r_o_valid || take) begin
            r_o <= i_data;
        end else begin
            r_s <= i_data;
        end
    end

    assign o_ready = !r_s_valid;
    assign o_valid = r_o_valid;
    assign o_data  = r_o;
endmodule

FILE: rtl/refraction_vector.sv
`timescale 1ns / 1ps
// Snell refraction of a unit incident direction d at a surface with unit
// normal n and index ratio w, all Q1.16 (w unsigned Q2.16). With c = -d.n
// and det = 1 - w^2(1 - c^2), det below tir_threshold raises the total
// reflection flag (tuser bit 0) and returns a zero vector; otherwise the
// result is normalize(w*d + (w*c - sqrt(det))*n), returned in 18-bit fields.
// A degenerate zero vector returns zero with the flag clear. The block is a
// fixed pipeline: one transfer per clock in and out while the master side
// keeps up. Most of its stages lie in the two pipelined square roots (22
// and 31 stages) and the 17-stage divider. All stages advance together;
// the output register plus a skid entry lets one more result land while
// the master side stalls, after which s_axis_tready drops until the skid
// drains. tir_threshold sits at byte address 0 (reset 1) and is only to
// be written while no item is in flight.
module refraction_vector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // APB register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // normal_x, normal_y, normal_z, incident_x, incident_y, incident_z,
    // index_ratio (18 bits each), 2 pad bits
    input  logic [127:0]  s_axis_tdata,
    // output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // refracted_x, refracted_y, refracted_z (18 bits each), 2 pad bits
    output logic [55:0]   m_axis_tdata,
    // total_reflection
    output logic [0:0]    m_axis_tuser
);
    import rfv_pkg::*;

    localparam logic signed [24:0] ONE25 = 25'sd1 <<< FRAC;
    localparam logic signed [30:0] ONE31 = 31'sd1 <<< FRAC;

    // ---------------- register port ----------------
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= TIR_THRESHOLD_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_TIR_THRESHOLD) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIR_THRESHOLD) ? {(32-THR_W)'(0), r_thr} : '0;

    // ---------------- global advance ----------------
    logic w_en;             // from the skid: no result parked in the skid entry
    assign s_axis_tready = w_en;

    // input unpack
    logic signed [FIELD_W-1:0] w_n [3];
    logic signed [FIELD_W-1:0] w_d [3];
    logic [FIELD_W-1:0]        w_w;

    for (genvar l = 0; l < 3; l++) begin : g_unpack
        assign w_n[l] = s_axis_tdata[FIELD_W*l +: FIELD_W];
        assign w_d[l] = s_axis_tdata[FIELD_W*(l+3) +: FIELD_W];
    end
    assign w_w = s_axis_tdata[FIELD_W*6 +: FIELD_W];

    // ---------------- S1: d*n, w*w, w*d ----------------
    logic                      r_s1_vld;
    logic signed [35:0]        r_s1_p  [3];
    logic [35:0]               r_s1_ww;
    logic [2:0][WD_W-1:0]      r_s1_wd;
    logic [2:0][FIELD_W-1:0]   r_s1_n;
    logic [FIELD_W-1:0]        r_s1_w;
    logic signed [36:0]        n_s1_wd [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_s1_wd[l] = $signed({1'b0, w_w}) * w_d[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_s1_p[l]  <= w_d[l] * w_n[l];
                r_s1_wd[l] <= n_s1_wd[l][FRAC +: WD_W];
                r_s1_n[l]  <= w_n[l];
            end
            r_s1_ww <= w_w * w_w;
            r_s1_w  <= w_w;
        end
    end

    // ---------------- S2: c = -(d.n >> F), w2 ----------------
    logic                      r_s2_vld;
    logic signed [20:0]        r_s2_c;
    logic [19:0]               r_s2_w2;
    logic [2:0][WD_W-1:0]      r_s2_wd;
    logic [2:0][FIELD_W-1:0]   r_s2_n;
    logic [FIELD_W-1:0]        r_s2_w;
    logic signed [37:0]        n_s2_dot;
    logic signed [21:0]        n_s2_c;

    always_comb begin
        n_s2_dot = 38'(r_s1_p[0]) + 38'(r_s1_p[1]) + 38'(r_s1_p[2]);
        n_s2_c   = -$signed(n_s2_dot[37:FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_c  <= n_s2_c[20:0];
            r_s2_w2 <= r_s1_ww[FRAC +: 20];
            r_s2_wd <= r_s1_wd;
            r_s2_n  <= r_s1_n;
            r_s2_w  <= r_s1_w;
        end
    end

    // ---------------- S3: c^2, w*c ----------------
    logic                      r_s3_vld;
    logic [23:0]               r_s3_c2;
    logic signed [WC_W-1:0]    r_s3_wc;
    logic [19:0]               r_s3_w2;
    logic [2:0][WD_W-1:0]      r_s3_wd;
    logic [2:0][FIELD_W-1:0]   r_s3_n;
    logic signed [41:0]        n_s3_cc;
    logic signed [39:0]        n_s3_wc;

    always_comb begin
        n_s3_cc = r_s2_c * r_s2_c;
        n_s3_wc = $signed({1'b0, r_s2_w}) * r_s2_c;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_c2 <= n_s3_cc[FRAC +: 24];
            r_s3_wc <= n_s3_wc[FRAC +: WC_W];
            r_s3_w2 <= r_s2_w2;
            r_s3_wd <= r_s2_wd;
            r_s3_n  <= r_s2_n;
        end
    end

    // ---------------- S4: w2 * (1 - c2) ----------------
    logic                      r_s4_vld;
    logic signed [45:0]        r_s4_prod;
    logic signed [WC_W-1:0]    r_s4_wc;
    logic [2:0][WD_W-1:0]      r_s4_wd;
    logic [2:0][FIELD_W-1:0]   r_s4_n;
    logic signed [24:0]        n_s4_omc;

    assign n_s4_omc = ONE25 - $signed({1'b0, r_s3_c2});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_prod <= $signed({1'b0, r_s3_w2}) * n_s4_omc;
            r_s4_wc   <= r_s3_wc;
            r_s4_wd   <= r_s3_wd;
            r_s4_n    <= r_s3_n;
        end
    end

    // ---------------- S5: det, threshold, radicand ----------------
    logic                      r_s5_vld;
    logic [RAD_A_W-1:0]        r_s5_x;
    t_side_a                   r_s5_side;
    logic signed [30:0]        n_s5_det;
    logic                      n_s5_tir;

    always_comb begin
        n_s5_det = ONE31 - 31'($signed(r_s4_prod[45:FRAC]));
        n_s5_tir = n_s5_det < $signed({(31-THR_W)'(0), r_thr});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // det stays below 2^28 whenever it passes the threshold
            r_s5_x         <= n_s5_tir ? '0 : {n_s5_det[27:0], FRAC'(0)};
            r_s5_side.tir  <= n_s5_tir;
            r_s5_side.wc   <= r_s4_wc;
            r_s5_side.n    <= r_s4_n;
            r_s5_side.wd   <= r_s4_wd;
        end
    end

    // ---------------- sqrt(det << F) ----------------
    logic                      w_sa_vld;
    logic [RAD_A_W/2-1:0]      w_sa_root;
    logic [$bits(t_side_a)-1:0] w_sa_side_raw;
    t_side_a                   w_sa_side;

    rfv_sqrt #(
        .RAD_W  (RAD_A_W),
        .SIDE_W ($bits(t_side_a))
    ) u_sqrt_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_vld),
        .i_rad   (r_s5_x),
        .i_side  (r_s5_side),
        .o_valid (w_sa_vld),
        .o_root  (w_sa_root),
        .o_side  (w_sa_side_raw)
    );
    assign w_sa_side = w_sa_side_raw;

    // ---------------- S6: k = wc - b ----------------
    logic                      r_s6_vld;
    logic signed [24:0]        r_s6_k;
    logic                      r_s6_tir;
    logic [2:0][WD_W-1:0]      r_s6_wd;
    logic [2:0][FIELD_W-1:0]   r_s6_n;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_k   <= 25'(w_sa_side.wc) - $signed({3'b0, w_sa_root});
            r_s6_tir <= w_sa_side.tir;
            r_s6_wd  <= w_sa_side.wd;
            r_s6_n   <= w_sa_side.n;
        end
    end

    // ---------------- S7: (k*n) >> F ----------------
    logic                      r_s7_vld;
    logic signed [26:0]        r_s7_kn [3];
    logic                      r_s7_tir;
    logic [2:0][WD_W-1:0]      r_s7_wd;
    logic signed [42:0]        n_s7_kn [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_s7_kn[l] = r_s6_k * $signed(r_s6_n[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_s7_kn[l] <= n_s7_kn[l][FRAC +: 27];
            end
            r_s7_tir <= r_s6_tir;
            r_s7_wd  <= r_s6_wd;
        end
    end

    // ---------------- S8: v = wd + kn ----------------
    logic                      r_s8_vld;
    logic signed [27:0]        r_s8_v [3];
    logic                      r_s8_tir;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_s8_v[l] <= 28'($signed(r_s7_wd[l])) + 28'(r_s7_kn[l]);
            end
            r_s8_tir <= r_s7_tir;
        end
    end

    // ---------------- S9: magnitude OR for normalize ----------------
    logic                      r_s9_vld;
    t_vec3                     r_s9_v;
    logic [MAG_W-1:0]          r_s9_m;
    t_flags                    r_s9_flags;
    logic [27:0]               n_s9_abs [3];
    logic [27:0]               n_s9_m;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_s9_abs[l] = r_s8_v[l][27] ? 28'(-r_s8_v[l]) : 28'(r_s8_v[l]);
        end
        n_s9_m = n_s9_abs[0] | n_s9_abs[1] | n_s9_abs[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_s9_v[l] <= V_W'(r_s8_v[l]);
            end
            r_s9_m           <= MAG_W'(n_s9_m);
            r_s9_flags.tir   <= r_s8_tir;
            r_s9_flags.zero  <= (n_s9_m == '0);
        end
    end

    // ---------------- normalize to [2^29, 2^30) ----------------
    logic                      w_nm_vld;
    t_vec3                     w_nm_v;
    t_flags                    w_nm_flags;

    rfv_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s9_vld),
        .i_v     (r_s9_v),
        .i_m     (r_s9_m),
        .i_flags (r_s9_flags),
        .o_valid (w_nm_vld),
        .o_v     (w_nm_v),
        .o_flags (w_nm_flags)
    );

    // ---------------- SQ: squares, sign and magnitude ----------------
    logic                      r_sq_vld;
    logic [60:0]               r_sq [3];
    t_side_b                   r_sq_side;
    logic signed [61:0]        n_sq [3];
    logic [V_W-1:0]            n_sq_neg_v [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sq[l]       = $signed(w_nm_v[l]) * $signed(w_nm_v[l]);
            n_sq_neg_v[l] = -w_nm_v[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_sq[l]              <= n_sq[l][60:0];
                r_sq_side.neg[l]     <= w_nm_v[l][V_W-1];
                r_sq_side.mag[l]     <= w_nm_v[l][V_W-1] ? n_sq_neg_v[l][MAG_W-1:0]
                                                         : w_nm_v[l][MAG_W-1:0];
            end
            r_sq_side.flags <= w_nm_flags;
        end
    end

    // ---------------- SS: sum of squares ----------------
    logic                      r_ss_vld;
    logic [RAD_B_W-1:0]        r_ss_sum;
    t_side_b                   r_ss_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ss_sum  <= RAD_B_W'(r_sq[0]) + RAD_B_W'(r_sq[1]) + RAD_B_W'(r_sq[2]);
            r_ss_side <= r_sq_side;
        end
    end

    // ---------------- length = sqrt(sum) ----------------
    logic                       w_sb_vld;
    logic [RAD_B_W/2-1:0]       w_sb_len;
    logic [$bits(t_side_b)-1:0] w_sb_side_raw;
    t_side_b                    w_sb_side;
    t_side_d                    w_dv_in_side;

    rfv_sqrt #(
        .RAD_W  (RAD_B_W),
        .SIDE_W ($bits(t_side_b))
    ) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_ss_vld),
        .i_rad   (r_ss_sum),
        .i_side  (r_ss_side),
        .o_valid (w_sb_vld),
        .o_root  (w_sb_len),
        .o_side  (w_sb_side_raw)
    );
    assign w_sb_side          = w_sb_side_raw;
    assign w_dv_in_side.flags = w_sb_side.flags;
    assign w_dv_in_side.neg   = w_sb_side.neg;

    // ---------------- divide by length ----------------
    logic                       w_dv_vld;
    logic [2:0][Q_W-1:0]        w_dv_q;
    logic [$bits(t_side_d)-1:0] w_dv_side_raw;
    t_side_d                    w_dv_side;

    rfv_div #(
        .SIDE_W ($bits(t_side_d))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sb_vld),
        .i_mag   (w_sb_side.mag),
        .i_len   (w_sb_len),
        .i_side  (w_dv_in_side),
        .o_valid (w_dv_vld),
        .o_q     (w_dv_q),
        .o_side  (w_dv_side_raw)
    );
    assign w_dv_side = w_dv_side_raw;

    // ---------------- FIN: sign, special cases ----------------
    // |v_i| never exceeds len, so the quotient fits 17 bits and needs no clamp
    logic                      r_fin_vld;
    t_result                   r_fin;
    logic signed [FIELD_W-1:0] n_fin [3];
    logic                      n_fin_kill;

    always_comb begin
        n_fin_kill = w_dv_side.flags.tir || w_dv_side.flags.zero;
        for (int l = 0; l < 3; l++) begin
            if (n_fin_kill) begin
                n_fin[l] = '0;
            end else if (w_dv_side.neg[l]) begin
                n_fin[l] = -$signed({1'b0, w_dv_q[l]});
            end else begin
                n_fin[l] = $signed({1'b0, w_dv_q[l]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin.x   <= n_fin[0];
            r_fin.y   <= n_fin[1];
            r_fin.z   <= n_fin[2];
            r_fin.tir <= w_dv_side.flags.tir;
        end
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_ss_vld  <= 1'b0;
            r_fin_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= s_axis_tvalid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= w_sa_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_sq_vld  <= w_nm_vld;
            r_ss_vld  <= r_sq_vld;
            r_fin_vld <= w_dv_vld;
        end
    end

    // ---------------- output buffer ----------------
    t_result w_out;

    rfv_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fin_vld),
        .i_data  (r_fin),
        .o_ready (w_en),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, w_out.z, w_out.y, w_out.x};
    assign m_axis_tuser = w_out.tir;

    // ---------------- checks ----------------
    a_tir_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("reflection result carries a nonzero vector");

    a_block_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input blocked with no result waiting");

    a_stall_holds_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_fin_vld) && $stable(r_fin))
        else $error("pipeline tail moved during a stall");
endmodule
